>>> hdl/efs_pkg.sv
package efs_pkg;

    localparam int WEIGHT_BITS = 24;
    localparam int TIME_BITS   = 32;

    localparam int CMD_BITS  = 3;
    localparam int MODE_BITS = 3;
    localparam int ANG_BITS  = 8;
    localparam int THR_BITS  = 23;
    localparam int MS_BITS   = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 23;

    // weight difference needs one bit more than a sample; compare also covers the threshold
    localparam int DIFF_BITS = WEIGHT_BITS + 1;
    localparam int CMP_BITS  = (DIFF_BITS > THR_BITS) ? DIFF_BITS : THR_BITS;

    // stream packing, fields from bit 0 up, padded to bytes
    localparam int IN_BITS    = TIME_BITS + CMD_BITS + WEIGHT_BITS;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = MODE_BITS + 5 * ANG_BITS + 2;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_UNARMED = 3'd0,
        MODE_ARMED   = 3'd1,
        MODE_LOADING = 3'd2,
        MODE_LOADED  = 3'd3,
        MODE_FIRE    = 3'd4,
        MODE_PURGE   = 3'd5,
        MODE_PURGED  = 3'd6
    } t_mode;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_NONE      = 3'd0,
        CMD_ARM       = 3'd1,
        CMD_SAFE      = 3'd2,
        CMD_FILL      = 3'd3,
        CMD_FILL_DONE = 3'd4,
        CMD_IGNITE    = 3'd5,
        CMD_VENT      = 3'd6,
        CMD_VENT_DONE = 3'd7
    } t_cmd;

    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_WEIGHT_THR = 3'd0;
    localparam t_cfg_idx CFG_BUZZER_MS  = 3'd1;
    localparam t_cfg_idx CFG_PYRO_MS    = 3'd2;
    localparam t_cfg_idx CFG_CAM_PERIOD = 3'd3;
    localparam t_cfg_idx CFG_BURN_LIMIT = 3'd4;

    localparam logic [THR_BITS-1:0] RST_WEIGHT_THR = 23'd450;
    localparam logic [MS_BITS-1:0]  RST_BUZZER_MS  = 16'd1000;
    localparam logic [MS_BITS-1:0]  RST_PYRO_MS    = 16'd2000;
    localparam logic [MS_BITS-1:0]  RST_CAM_PERIOD = 16'd1500;
    localparam logic [MS_BITS-1:0]  RST_BURN_LIMIT = 16'd15000;

    // servo positions in degrees
    localparam logic [ANG_BITS-1:0] ANG_FUEL_CLOSED  = 8'd6;
    localparam logic [ANG_BITS-1:0] ANG_FUEL_OPEN    = 8'd60;
    localparam logic [ANG_BITS-1:0] ANG_OX_CLOSED    = 8'd5;
    localparam logic [ANG_BITS-1:0] ANG_OX_OPEN      = 8'd65;
    localparam logic [ANG_BITS-1:0] ANG_LOAD_CLOSED  = 8'd10;
    localparam logic [ANG_BITS-1:0] ANG_LOAD_OPEN    = 8'd70;
    localparam logic [ANG_BITS-1:0] ANG_PURGE_CLOSED = 8'd3;
    localparam logic [ANG_BITS-1:0] ANG_PURGE_OPEN   = 8'd65;
    localparam logic [ANG_BITS-1:0] ANG_CAM_REST     = 8'd70;
    localparam logic [ANG_BITS-1:0] ANG_CAM_PRESS    = 8'd60;

    // valve ramp window, ms after fire
    localparam logic [TIME_BITS-1:0] RAMP_START = TIME_BITS'(100);
    localparam logic [TIME_BITS-1:0] RAMP_END   = TIME_BITS'(3100);
    localparam int RAMP_P_BITS = 12;

    // floor(9p/500) = (9p * FUEL_K) >> FUEL_SH, floor(p/50) = (p * OX_K) >> OX_SH,
    // exact for p <= 3000
    localparam int FUEL_SH = 24;
    localparam int OX_SH   = 22;
    localparam logic [15:0] FUEL_K = 16'd33555;
    localparam logic [16:0] OX_K   = 17'd83887;

endpackage

>>> hdl/engine_fire_sequencer.sv
// Engine fire sequencer.
// Pipeline: input register, then result register; m_axis is driven from the result register.
// Throughput: one item per cycle while m_axis_tready holds; mode, timers and servo state
//   update in the result stage, so each item sees everything the previous one left.
// Reset: i_rst_n synchronous, active low; clears pipeline valids and state, loads config
//   registers with their defaults. cfg port is always ready.
module engine_fire_sequencer (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [31:0] now_ms, [34:32] command, [58:35] tank_weight, rest zero
    input  logic [efs_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [2:0] mode, [10:3] fuel_angle, [18:11] oxidiser_angle, [26:19] load_valve_angle,
    // [34:27] purge_valve_angle, [42:35] camera_angle, [43] pyro_on, [44] buzzer_on
    output logic [efs_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // config writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [efs_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [efs_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);

    localparam int TB = efs_pkg::TIME_BITS;
    localparam int WB = efs_pkg::WEIGHT_BITS;
    localparam int AB = efs_pkg::ANG_BITS;
    localparam int MB = efs_pkg::MS_BITS;
    localparam int PB = efs_pkg::RAMP_P_BITS;

    // ---------------- config registers ----------------
    logic [efs_pkg::THR_BITS-1:0] r_weight_thr;
    logic [MB-1:0]                r_buzzer_ms;
    logic [MB-1:0]                r_pyro_ms;
    logic [MB-1:0]                r_cam_period;
    logic [MB-1:0]                r_burn_limit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight_thr <= efs_pkg::RST_WEIGHT_THR;
            r_buzzer_ms  <= efs_pkg::RST_BUZZER_MS;
            r_pyro_ms    <= efs_pkg::RST_PYRO_MS;
            r_cam_period <= efs_pkg::RST_CAM_PERIOD;
            r_burn_limit <= efs_pkg::RST_BURN_LIMIT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                efs_pkg::CFG_WEIGHT_THR: r_weight_thr <= i_cfg_data[efs_pkg::THR_BITS-1:0];
                efs_pkg::CFG_BUZZER_MS:  r_buzzer_ms  <= i_cfg_data[MB-1:0];
                efs_pkg::CFG_PYRO_MS:    r_pyro_ms    <= i_cfg_data[MB-1:0];
                efs_pkg::CFG_CAM_PERIOD: r_cam_period <= i_cfg_data[MB-1:0];
                efs_pkg::CFG_BURN_LIMIT: r_burn_limit <= i_cfg_data[MB-1:0];
                default: ;  // unused indexes dropped
            endcase
        end
    end

    // ---------------- pipeline handshake ----------------
    // Result stage advances when the output register is empty or being drained;
    // input stage takes a new transfer whenever its content moves on.
    logic r_in_valid;
    logic r_out_valid;
    logic out_load;
    logic in_load;

    assign out_load      = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || !r_out_valid || m_axis_tready;
    assign in_load       = s_axis_tvalid && s_axis_tready;

    // ---------------- input register ----------------
    logic [TB-1:0]                 r_in_now;
    logic [efs_pkg::CMD_BITS-1:0]  r_in_cmd;
    logic [WB-1:0]                 r_in_weight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in_now    <= s_axis_tdata[TB-1:0];
            r_in_cmd    <= s_axis_tdata[TB +: efs_pkg::CMD_BITS];
            r_in_weight <= s_axis_tdata[TB + efs_pkg::CMD_BITS +: WB];
        end
    end

    // ---------------- sequencer state ----------------
    efs_pkg::t_mode r_mode;
    logic [WB-1:0]  r_armed_weight;
    logic [TB-1:0]  r_fire_start;
    logic [TB-1:0]  r_cam_time;
    logic           r_cam_flag;
    logic           r_pyro_flag;
    logic           r_buzzer_flag;
    logic [AB-1:0]  r_ang_fuel;
    logic [AB-1:0]  r_ang_ox;
    logic [AB-1:0]  r_ang_load;
    logic [AB-1:0]  r_ang_purge;
    logic [AB-1:0]  r_ang_cam;

    // ---------------- per-item datapath ----------------
    efs_pkg::t_cmd  cmd;
    logic signed [efs_pkg::DIFF_BITS-1:0] weight_diff;
    logic [efs_pkg::DIFF_BITS-1:0]        weight_abs;
    logic           weight_moved;
    efs_pkg::t_mode mode_pre;       // mode after the loading weight check
    logic           fire_take;      // fire command accepted this item
    logic [TB-1:0]  fire_base;
    logic [TB-1:0]  cam_base;
    logic [TB-1:0]  elapsed;
    logic [TB-1:0]  cam_elapsed;
    logic [TB-1:0]  ramp_diff;
    logic [PB-1:0]  ramp_p;
    logic [PB+2:0]  ramp_x9;
    logic [PB+18:0] fuel_prod;
    logic [PB+16:0] ox_prod;
    logic [AB-1:0]  fuel_ramp;
    logic [AB-1:0]  ox_ramp;

    assign cmd = efs_pkg::t_cmd'(r_in_cmd);

    // |weight - armed weight| against the loading threshold
    assign weight_diff = efs_pkg::DIFF_BITS'(signed'(r_in_weight))
                       - efs_pkg::DIFF_BITS'(signed'(r_armed_weight));
    assign weight_abs  = weight_diff[efs_pkg::DIFF_BITS-1] ? efs_pkg::DIFF_BITS'(-weight_diff)
                                                          : efs_pkg::DIFF_BITS'(weight_diff);
    assign weight_moved = efs_pkg::CMP_BITS'(weight_abs) >= efs_pkg::CMP_BITS'(r_weight_thr);

    assign mode_pre = (r_mode == efs_pkg::MODE_LOADING && weight_moved) ?
                      efs_pkg::MODE_LOADED : r_mode;

    assign fire_take = (cmd == efs_pkg::CMD_IGNITE) && (mode_pre != efs_pkg::MODE_UNARMED)
                    && (mode_pre != efs_pkg::MODE_FIRE);

    // a fresh fire restarts both timers at this item's timestamp
    assign fire_base   = fire_take ? r_in_now : r_fire_start;
    assign cam_base    = fire_take ? r_in_now : r_cam_time;
    assign elapsed     = r_in_now - fire_base;
    assign cam_elapsed = r_in_now - cam_base;

    // valve ramp: fuel 6 + floor(54p/3000) = 6 + floor(9p/500), ox 5 + floor(p/50)
    assign ramp_diff = elapsed - efs_pkg::RAMP_START;
    assign ramp_p    = ramp_diff[PB-1:0];
    assign ramp_x9   = {ramp_p, 3'b000} + (PB+3)'(ramp_p);
    assign fuel_prod = (PB+19)'(ramp_x9) * (PB+19)'(efs_pkg::FUEL_K);
    assign ox_prod   = (PB+17)'(ramp_p) * (PB+17)'(efs_pkg::OX_K);
    assign fuel_ramp = efs_pkg::ANG_FUEL_CLOSED + AB'(fuel_prod[PB+18:efs_pkg::FUEL_SH]);
    assign ox_ramp   = efs_pkg::ANG_OX_CLOSED + AB'(ox_prod[PB+16:efs_pkg::OX_SH]);

    efs_pkg::t_mode n_mode;
    logic [WB-1:0]  n_armed_weight;
    logic [TB-1:0]  n_fire_start;
    logic [TB-1:0]  n_cam_time;
    logic           n_cam_flag;
    logic           n_pyro_flag;
    logic           n_buzzer_flag;
    logic [AB-1:0]  n_ang_fuel;
    logic [AB-1:0]  n_ang_ox;
    logic [AB-1:0]  n_ang_load;
    logic [AB-1:0]  n_ang_purge;
    logic [AB-1:0]  n_ang_cam;

    always_comb begin
        n_mode         = mode_pre;
        n_armed_weight = r_armed_weight;
        n_fire_start   = r_fire_start;
        n_cam_time     = r_cam_time;
        n_cam_flag     = r_cam_flag;
        n_pyro_flag    = r_pyro_flag;
        n_buzzer_flag  = r_buzzer_flag;
        n_ang_fuel     = r_ang_fuel;
        n_ang_ox       = r_ang_ox;
        n_ang_load     = (r_mode == efs_pkg::MODE_LOADING && weight_moved) ?
                         efs_pkg::ANG_LOAD_CLOSED : r_ang_load;
        n_ang_purge    = r_ang_purge;
        n_ang_cam      = r_ang_cam;

        // commands; unarmed accepts only arm
        if (mode_pre != efs_pkg::MODE_UNARMED || cmd == efs_pkg::CMD_ARM) begin
            case (cmd)
                efs_pkg::CMD_ARM: begin
                    n_mode         = efs_pkg::MODE_ARMED;
                    n_armed_weight = r_in_weight;
                end
                efs_pkg::CMD_SAFE: begin
                    n_mode        = efs_pkg::MODE_UNARMED;
                    n_buzzer_flag = 1'b0;
                    n_cam_flag    = 1'b0;
                    n_ang_fuel    = efs_pkg::ANG_FUEL_CLOSED;
                    n_ang_ox      = efs_pkg::ANG_OX_CLOSED;
                    n_ang_load    = efs_pkg::ANG_LOAD_CLOSED;
                    n_ang_purge   = efs_pkg::ANG_PURGE_CLOSED;
                end
                efs_pkg::CMD_FILL: begin
                    if (mode_pre == efs_pkg::MODE_ARMED) begin
                        n_mode     = efs_pkg::MODE_LOADING;
                        n_ang_load = efs_pkg::ANG_LOAD_OPEN;
                    end
                end
                efs_pkg::CMD_FILL_DONE: begin
                    if (mode_pre == efs_pkg::MODE_LOADING) begin
                        n_mode     = efs_pkg::MODE_LOADED;
                        n_ang_load = efs_pkg::ANG_LOAD_CLOSED;
                    end
                end
                efs_pkg::CMD_IGNITE: begin
                    if (fire_take) begin
                        n_mode        = efs_pkg::MODE_FIRE;
                        n_fire_start  = r_in_now;
                        n_cam_time    = r_in_now;
                        n_buzzer_flag = 1'b1;
                        n_pyro_flag   = 1'b1;
                        n_cam_flag    = 1'b1;
                    end
                end
                efs_pkg::CMD_VENT: begin
                    n_mode      = efs_pkg::MODE_PURGE;
                    n_ang_purge = efs_pkg::ANG_PURGE_OPEN;
                    n_ang_ox    = efs_pkg::ANG_OX_OPEN;
                end
                efs_pkg::CMD_VENT_DONE: begin
                    n_mode      = efs_pkg::MODE_PURGED;
                    n_ang_ox    = efs_pkg::ANG_OX_CLOSED;
                    n_ang_purge = efs_pkg::ANG_PURGE_CLOSED;
                end
                default: ;  // no command
            endcase
        end

        // fire timing, relative to the (possibly just restarted) fire start
        if (n_mode == efs_pkg::MODE_FIRE) begin
            if (elapsed >= TB'(r_buzzer_ms)) begin
                n_buzzer_flag = 1'b0;
            end
            if (elapsed > TB'(r_pyro_ms)) begin
                n_pyro_flag = 1'b0;
            end

            if (elapsed >= efs_pkg::RAMP_START && elapsed <= efs_pkg::RAMP_END) begin
                n_ang_fuel = fuel_ramp;
                n_ang_ox   = ox_ramp;
            end else if (elapsed > efs_pkg::RAMP_END && elapsed < TB'(r_burn_limit)) begin
                n_ang_fuel = efs_pkg::ANG_FUEL_OPEN;
                n_ang_ox   = efs_pkg::ANG_OX_OPEN;
            end

            if (cam_elapsed >= TB'(r_cam_period) && elapsed < TB'(r_burn_limit)) begin
                n_cam_time = r_in_now;
                n_cam_flag = !n_cam_flag;
                n_ang_cam  = n_cam_flag ? efs_pkg::ANG_CAM_PRESS : efs_pkg::ANG_CAM_REST;
            end

            // past the burn limit; exactly at a limit beyond the ramp window valves stay put
            if (elapsed > TB'(r_burn_limit)) begin
                n_ang_fuel = efs_pkg::ANG_FUEL_CLOSED;
                n_ang_ox   = efs_pkg::ANG_OX_CLOSED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= efs_pkg::MODE_UNARMED;
            r_armed_weight <= '0;
            r_fire_start   <= '0;
            r_cam_time     <= '0;
            r_cam_flag     <= 1'b0;
            r_pyro_flag    <= 1'b0;
            r_buzzer_flag  <= 1'b0;
            r_ang_fuel     <= efs_pkg::ANG_FUEL_CLOSED;
            r_ang_ox       <= efs_pkg::ANG_OX_CLOSED;
            r_ang_load     <= efs_pkg::ANG_LOAD_CLOSED;
            r_ang_purge    <= efs_pkg::ANG_PURGE_CLOSED;
            r_ang_cam      <= efs_pkg::ANG_CAM_REST;
        end else if (out_load) begin
            r_mode         <= n_mode;
            r_armed_weight <= n_armed_weight;
            r_fire_start   <= n_fire_start;
            r_cam_time     <= n_cam_time;
            r_cam_flag     <= n_cam_flag;
            r_pyro_flag    <= n_pyro_flag;
            r_buzzer_flag  <= n_buzzer_flag;
            r_ang_fuel     <= n_ang_fuel;
            r_ang_ox       <= n_ang_ox;
            r_ang_load     <= n_ang_load;
            r_ang_purge    <= n_ang_purge;
            r_ang_cam      <= n_ang_cam;
        end
    end

    // ---------------- result register ----------------
    logic [efs_pkg::OUT_TDATA_W-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= efs_pkg::OUT_TDATA_W'({n_buzzer_flag, n_pyro_flag, n_ang_cam,
                                                 n_ang_purge, n_ang_load, n_ang_ox,
                                                 n_ang_fuel, n_mode});
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
